// ===== hdl/wsh_pkg.sv =====
// Shared constants, types and hash helpers for the weighted simhash block.
package wsh_pkg;

   localparam int MAX_SEGMENTS = 8;
   localparam int MAX_OUT      = 8;
   localparam int SEG_LIMIT    = (MAX_SEGMENTS < MAX_OUT) ? MAX_SEGMENTS : MAX_OUT;
   localparam int SEG_IDX_W    = (SEG_LIMIT > 1) ? $clog2(SEG_LIMIT) : 1;
   localparam int SEG_BITS     = 32;
   localparam int CNT_W        = 48;
   localparam int ROW_W        = SEG_BITS * CNT_W;
   localparam int CFG_W        = 4;
   localparam int WIDX_W       = 3;
   localparam int AMT_W        = 32;

   localparam logic [31:0] C1 = 32'hcc9e2d51;
   localparam logic [31:0] C2 = 32'h1b873593;
   localparam logic [31:0] C3 = 32'he6546b64;
   localparam logic [31:0] C4 = 32'h85ebca6b;
   localparam logic [31:0] C5 = 32'hc2b2ae35;
   localparam int ROT_K = 15;
   localparam int ROT_H = 13;
   localparam logic [31:0] KEY_LEN = 32'd4;

   localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
   localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

   typedef struct packed {
      logic                 capture;
      logic                 key1;
      logic                 key2;
      logic                 mix1;
      logic                 mix2;
      logic                 upd;
      logic                 frd;
      logic                 fout;
      logic                 clear_all;
      logic                 last;
      logic [SEG_IDX_W-1:0] seg;
   } cmd_type;

   typedef struct packed {
      logic [SEG_IDX_W-1:0] last_seg;
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

endpackage

// ===== hdl/weighted_simhash.sv =====
// Top level of the weighted simhash signature generator.
// An item is taken at a clock edge with start high and busy low. After that edge busy stays
// high until the last of the N active segments has been handled, N being the active segment
// count (1 to 8). On an add item each segment's chained hash runs through two registered
// multiplies and then one read-modify-write of its 32-counter row. The next item can be taken
// at the end of the first cycle with busy low. Words leave one per active segment, each on
// the rsp_ ports for a single cycle with rsp_strobe high, the last one in the first cycle
// after busy falls. The receiver cannot stall, so it must take every word as it comes. After
// reset the counters read as zero at once.
module weighted_simhash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [31:0]                   req_token,
   input  logic [15:0]                   req_weight,
   input  logic [15:0]                   req_similarity,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_word,
   output logic [wsh_pkg::WIDX_W-1:0]    rsp_word_index,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [wsh_pkg::CFG_W-1:0]     csr_wr_data
);
   import wsh_pkg::*;

   cmd_type    cmd;
   status_type status;

   wsh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   wsh_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_token      (req_token),
      .req_weight     (req_weight),
      .req_similarity (req_similarity),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hdl/wsh_ctrl.sv =====
// Sequencer for the weighted simhash block: key steps per item, mix, update, read and output steps per segment.
module wsh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  wsh_pkg::status_type status,
   output logic                busy,
   output wsh_pkg::cmd_type    cmd
);
   import wsh_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_KEY1 = 8'b0000_0010,
      ST_KEY2 = 8'b0000_0100,
      ST_MIX1 = 8'b0000_1000,
      ST_MIX2 = 8'b0001_0000,
      ST_UPD  = 8'b0010_0000,
      ST_FRD  = 8'b0100_0000,
      ST_FOUT = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [SEG_IDX_W-1:0] seg_ff, seg_in;
   logic                 at_last;

   assign at_last = (seg_ff == status.last_seg);
   assign busy    = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      case (state_ff)
         ST_IDLE: begin
            seg_in = '0;
            if (start) begin
               state_in = req_kind ? ST_FRD : ST_KEY1;
            end
         end
         ST_KEY1: state_in = ST_KEY2;
         ST_KEY2: state_in = ST_MIX1;
         ST_MIX1: state_in = ST_MIX2;
         ST_MIX2: state_in = ST_UPD;
         ST_UPD: begin
            if (at_last) begin
               state_in = ST_IDLE;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_MIX1;
            end
         end
         ST_FRD: state_in = ST_FOUT;
         ST_FOUT: begin
            if (at_last) begin
               state_in = ST_IDLE;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_FRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && start;
      cmd.key1      = (state_ff == ST_KEY1);
      cmd.key2      = (state_ff == ST_KEY2);
      cmd.mix1      = (state_ff == ST_MIX1);
      cmd.mix2      = (state_ff == ST_MIX2);
      cmd.upd       = (state_ff == ST_UPD);
      cmd.frd       = (state_ff == ST_FRD);
      cmd.fout      = (state_ff == ST_FOUT);
      cmd.clear_all = (state_ff == ST_FOUT) && at_last;
      cmd.last      = at_last;
      cmd.seg       = seg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
   end

endmodule

// ===== hdl/wsh_dp.sv =====
// Datapath: murmur3 hash chain, counter row memory, saturating update and word output.
module wsh_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  wsh_pkg::cmd_type              cmd,
   output wsh_pkg::status_type           status,
   input  logic [31:0]                   req_token,
   input  logic [15:0]                   req_weight,
   input  logic [15:0]                   req_similarity,
   input  logic                          csr_wr_en,
   input  logic [wsh_pkg::CFG_W-1:0]     csr_wr_data,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_word,
   output logic [wsh_pkg::WIDX_W-1:0]    rsp_word_index,
   output logic                          rsp_last
);
   import wsh_pkg::*;

   logic [CFG_W-1:0]     seg_count_ff;
   logic [31:0]          token_ff;
   logic [15:0]          weight_ff;
   logic [15:0]          sim_ff;
   logic [31:0]          k1_ff;
   logic [31:0]          key_ff;
   logic [AMT_W-1:0]     amount_ff;
   logic [31:0]          seed_ff;
   logic [31:0]          m1_ff;
   logic [31:0]          m2_ff;
   logic [ROW_W-1:0]     cnt_mem [SEG_LIMIT];
   logic [SEG_LIMIT-1:0] row_valid_ff;
   logic [ROW_W-1:0]     rd_row_ff;
   logic                 rd_valid_ff;
   logic                 rsp_strobe_ff;
   logic [31:0]          rsp_word_ff;
   logic [WIDX_W-1:0]    rsp_index_ff;
   logic                 rsp_last_ff;

   logic [31:0]          h_pre, h_rot, h_mul5, f1, f2, hash;
   logic [ROW_W-1:0]     row_new;
   logic [31:0]          word_new;
   logic [CFG_W-1:0]     nseg;

   // active segment count, clamped to 1..SEG_LIMIT
   always_comb begin
      if (seg_count_ff == '0) begin
         nseg = CFG_W'(1);
      end else if (seg_count_ff > CFG_W'(SEG_LIMIT)) begin
         nseg = CFG_W'(SEG_LIMIT);
      end else begin
         nseg = seg_count_ff;
      end
      status.last_seg = SEG_IDX_W'(nseg - CFG_W'(1));
   end

   always_comb begin
      h_pre  = rotl(seed_ff ^ key_ff, ROT_H);
      h_rot  = h_pre + (h_pre << 2) + C3;
      h_mul5 = h_rot ^ KEY_LEN;
      f1     = h_mul5 ^ (h_mul5 >> 16);
      f2     = m1_ff ^ (m1_ff >> 13);
      hash   = m2_ff ^ (m2_ff >> 16);
   end

   always_comb begin
      logic signed [CNT_W:0] c, v;
      logic [CNT_W-1:0]      cur;
      for (int b = 0; b < SEG_BITS; b++) begin
         cur = rd_valid_ff ? rd_row_ff[b*CNT_W +: CNT_W] : '0;
         c   = {cur[CNT_W-1], cur};
         if (hash[b]) begin
            v = c + {{(CNT_W+1-AMT_W){1'b0}}, amount_ff};
         end else begin
            v = c - {{(CNT_W+1-AMT_W){1'b0}}, amount_ff};
         end
         if (v[CNT_W] != v[CNT_W-1]) begin
            row_new[b*CNT_W +: CNT_W] = v[CNT_W] ? CNT_MIN : CNT_MAX;
         end else begin
            row_new[b*CNT_W +: CNT_W] = v[CNT_W-1:0];
         end
         word_new[b] = rd_valid_ff && !cur[CNT_W-1] && (cur[CNT_W-2:0] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         seg_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         token_ff  <= req_token;
         weight_ff <= req_weight;
         sim_ff    <= req_similarity;
      end
      if (cmd.key1) begin
         k1_ff     <= token_ff * C1;
         amount_ff <= AMT_W'(weight_ff) * AMT_W'(sim_ff);
      end
      if (cmd.key2) begin
         key_ff  <= rotl(k1_ff, ROT_K) * C2;
         seed_ff <= '0;
      end
      if (cmd.mix1) begin
         m1_ff <= f1 * C4;
      end
      if (cmd.mix2) begin
         m2_ff <= f2 * C5;
      end
      if (cmd.upd) begin
         seed_ff <= hash;
      end
   end

   // counter rows
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         cnt_mem[cmd.seg] <= row_new;
      end
      if (cmd.mix2 || cmd.frd) begin
         rd_row_ff <= cnt_mem[cmd.seg];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.mix2 || cmd.frd) begin
            rd_valid_ff <= row_valid_ff[cmd.seg];
         end
         if (cmd.clear_all) begin
            row_valid_ff <= '0;
         end else if (cmd.upd) begin
            row_valid_ff[cmd.seg] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.fout;
      end
      if (cmd.fout) begin
         rsp_word_ff  <= word_new;
         rsp_index_ff <= WIDX_W'(cmd.seg);
         rsp_last_ff  <= cmd.last;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== hdl/wsh_checker.sv =====
// Port-level checks for the weighted simhash block, bound to the top level.
module wsh_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_kind,
   input logic                          rsp_strobe,
   input logic [wsh_pkg::WIDX_W-1:0]    rsp_word_index,
   input logic                          rsp_last
);
   import wsh_pkg::*;

   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_kind) |=> busy ##1 busy)
      else $error("add item did not keep the block busy");

   a_finish_gap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind) |=> (busy && !rsp_strobe))
      else $error("finish item produced a word too early");

   a_more_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("block idle while signature words remain");

   a_index_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word_index != '0)) |->
         ($past(rsp_strobe, 2) && ($past(rsp_word_index, 2) == rsp_word_index - 1'b1)))
      else $error("signature word index out of sequence");

endmodule

bind weighted_simhash wsh_checker u_wsh_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_strobe     (rsp_strobe),
   .rsp_word_index (rsp_word_index),
   .rsp_last       (rsp_last)
);
